// ----- hw/rtl/sminv_pkg.sv -----
// shared constants, types and cofactor index tables for the small matrix inverse
package sminv_pkg;

    localparam int DW     = 32;
    localparam int FB     = 16;
    localparam int QW     = 2 * FB;
    localparam int PW     = 2 * DW;
    localparam int CW     = 2 * DW + 1;
    localparam int LOW    = 2 * DW + 1;
    localparam int DTW    = 3 * DW + 4;
    localparam int LW     = DW + QW + 1;
    localparam int NM     = 9;
    localparam int NSTG   = 6 + QW;
    localparam int ADDR_W = 3;

    localparam logic [1:0] SIZE_2X2 = 2'd2;
    localparam logic [1:0] SIZE_RST = 2'd3;
    localparam logic       REG_SIZE = 1'b0;

    typedef logic signed [DW-1:0]  elem_t;
    typedef logic signed [PW-1:0]  prod_t;
    typedef logic signed [CW-1:0]  cof_t;
    typedef logic signed [LOW-1:0] part_t;
    typedef logic signed [DTW-1:0] det_t;
    typedef logic        [DTW-1:0] mag_t;
    typedef logic        [QW-1:0]  quo_t;

    // cofactor k = a[A]*a[B] - a[C]*a[D]
    localparam int CF_A [NM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int CF_B [NM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int CF_C [NM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int CF_D [NM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

// ----- hw/rtl/small_matrix_inverse.sv -----
// small matrix inverse top level: pipelined adjugate and restoring divider datapath
//
// input channel in_valid/in_ready carries one matrix m00..m22 (signed Q16.16)
// output channel out_valid/out_ready carries inverse i00..i22 plus singular and
// saturated flags; one result per item, in order
// matrix_size register at byte address 0 (apb, pready always high): 2 selects
// 2x2 mode, anything else 3x3; it is sampled when an item enters
// each item passes through 38 register stages: five stages of products,
// cofactors, determinant partial products, determinant sum and magnitudes,
// 32 restoring divide stages (one quotient bit each), one saturation stage
// one item per cycle unless out_ready stalls; each stage holds an item and valid bit
// when out_ready is low the result holds and the stages behind it keep filling
// empty slots, so in_ready drops only once every stage is occupied
// reset empties the pipeline and sets matrix_size to 3
module small_matrix_inverse
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sminv_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [31:0]             m00,
    input  logic signed [31:0]             m01,
    input  logic signed [31:0]             m02,
    input  logic signed [31:0]             m10,
    input  logic signed [31:0]             m11,
    input  logic signed [31:0]             m12,
    input  logic signed [31:0]             m20,
    input  logic signed [31:0]             m21,
    input  logic signed [31:0]             m22,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [31:0]             i00,
    output logic signed [31:0]             i01,
    output logic signed [31:0]             i02,
    output logic signed [31:0]             i10,
    output logic signed [31:0]             i11,
    output logic signed [31:0]             i12,
    output logic signed [31:0]             i20,
    output logic signed [31:0]             i21,
    output logic signed [31:0]             i22,
    output logic                           singular,
    output logic                           saturated
);

    localparam int NM   = sminv_pkg::NM;
    localparam int QW   = sminv_pkg::QW;
    localparam int DW   = sminv_pkg::DW;
    localparam int DTW  = sminv_pkg::DTW;
    localparam int LW   = sminv_pkg::LW;
    localparam int NSTG = sminv_pkg::NSTG;
    localparam int SD   = 5;

    logic [1:0]                 size_reg;
    logic [NSTG-1:0]            vld_reg;
    logic [NSTG-1:0]            en;
    sminv_pkg::elem_t           in_a [NM];

    sminv_pkg::prod_t           ab_s1_reg [NM];
    sminv_pkg::prod_t           cd_s1_reg [NM];
    sminv_pkg::elem_t           a_s1_reg [5];
    logic                       two_s1_reg;

    sminv_pkg::cof_t            num_s2_next [NM];
    sminv_pkg::cof_t            num_s2_reg [NM];
    sminv_pkg::elem_t           a_s2_reg [3];
    sminv_pkg::det_t            d2_s2_reg;
    logic                       two_s2_reg;

    sminv_pkg::part_t           plo_s3_reg [3];
    sminv_pkg::part_t           phi_s3_reg [3];
    sminv_pkg::cof_t            num_s3_reg [NM];
    sminv_pkg::det_t            d2_s3_reg;
    logic                       two_s3_reg;

    sminv_pkg::det_t            det_s4_next;
    sminv_pkg::det_t            det_s4_reg;
    sminv_pkg::cof_t            num_s4_reg [NM];

    sminv_pkg::mag_t            nmag_s5_next [NM];
    sminv_pkg::mag_t            nmag_s5_reg [NM];
    sminv_pkg::mag_t            dmag_s5_next;
    sminv_pkg::mag_t            dmag_s5_reg;
    logic [NM-1:0]              neg_s5_next;
    logic [NM-1:0]              neg_s5_reg;
    logic [NM-1:0]              ovf_s5_next;
    logic [NM-1:0]              ovf_s5_reg;
    logic                       sing_s5_reg;

    sminv_pkg::mag_t            rem_next [QW][NM];
    sminv_pkg::mag_t            rem_reg [QW][NM];
    sminv_pkg::quo_t            q_next [QW][NM];
    sminv_pkg::quo_t            q_reg [QW][NM];
    sminv_pkg::mag_t            dmag_reg [QW];
    logic [NM-1:0]              neg_reg [QW];
    logic [NM-1:0]              ovf_reg [QW];
    logic [QW-1:0]              sing_reg;

    sminv_pkg::elem_t           res_next [NM];
    sminv_pkg::elem_t           res_reg [NM];
    logic                       sat_next;
    logic                       sat_reg;
    logic                       sing_out_reg;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == sminv_pkg::REG_SIZE) ? {30'd0, size_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= sminv_pkg::SIZE_RST;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == sminv_pkg::REG_SIZE))
        begin
            size_reg <= pwdata[1:0];
        end
    end

    // stage flow control
    always_comb
    begin
        en[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int s = NSTG - 2; s >= 0; s--)
        begin
            en[s] = !vld_reg[s] || en[s+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int s = 1; s < NSTG; s++)
            begin
                if (en[s])
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    assign in_a[0] = m00;
    assign in_a[1] = m01;
    assign in_a[2] = m02;
    assign in_a[3] = m10;
    assign in_a[4] = m11;
    assign in_a[5] = m12;
    assign in_a[6] = m20;
    assign in_a[7] = m21;
    assign in_a[8] = m22;

    // stage 1: element products
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int k = 0; k < NM; k++)
            begin
                ab_s1_reg[k] <= in_a[sminv_pkg::CF_A[k]] * in_a[sminv_pkg::CF_B[k]];
                cd_s1_reg[k] <= in_a[sminv_pkg::CF_C[k]] * in_a[sminv_pkg::CF_D[k]];
            end
            for (int k = 0; k < 5; k++)
            begin
                a_s1_reg[k] <= in_a[k];
            end
            two_s1_reg <= (size_reg == sminv_pkg::SIZE_2X2);
        end
    end

    // stage 2: cofactors, or the 2x2 adjugate
    always_comb
    begin
        for (int k = 0; k < NM; k++)
        begin
            num_s2_next[k] = sminv_pkg::cof_t'(ab_s1_reg[k]) - sminv_pkg::cof_t'(cd_s1_reg[k]);
        end
        if (two_s1_reg)
        begin
            for (int k = 0; k < NM; k++)
            begin
                num_s2_next[k] = '0;
            end
            num_s2_next[0] = sminv_pkg::cof_t'(a_s1_reg[4]);
            num_s2_next[1] = -sminv_pkg::cof_t'(a_s1_reg[1]);
            num_s2_next[3] = -sminv_pkg::cof_t'(a_s1_reg[3]);
            num_s2_next[4] = sminv_pkg::cof_t'(a_s1_reg[0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            num_s2_reg <= num_s2_next;
            for (int k = 0; k < 3; k++)
            begin
                a_s2_reg[k] <= a_s1_reg[k];
            end
            d2_s2_reg  <= sminv_pkg::det_t'(sminv_pkg::cof_t'(ab_s1_reg[8])
                          - sminv_pkg::cof_t'(cd_s1_reg[8]));
            two_s2_reg <= two_s1_reg;
        end
    end

    // stage 3: determinant partial products, cofactor split in low and high halves
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int j = 0; j < 3; j++)
            begin
                plo_s3_reg[j] <= a_s2_reg[j] * $signed({1'b0, num_s2_reg[3*j][DW-1:0]});
                phi_s3_reg[j] <= a_s2_reg[j] * $signed(num_s2_reg[3*j][sminv_pkg::CW-1:DW]);
            end
            num_s3_reg <= num_s2_reg;
            d2_s3_reg  <= d2_s2_reg;
            two_s3_reg <= two_s2_reg;
        end
    end

    // stage 4: determinant sum, or the 2x2 determinant in 2x2 mode
    always_comb
    begin
        det_s4_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            det_s4_next = det_s4_next + (sminv_pkg::det_t'(phi_s3_reg[j]) <<< DW)
                          + sminv_pkg::det_t'(plo_s3_reg[j]);
        end
        if (two_s3_reg)
        begin
            det_s4_next = d2_s3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            det_s4_reg <= det_s4_next;
            num_s4_reg <= num_s3_reg;
        end
    end

    // stage 5: magnitudes, signs, range check and singular flag
    always_comb
    begin
        dmag_s5_next = det_s4_reg[DTW-1] ? sminv_pkg::mag_t'(-det_s4_reg)
                                         : sminv_pkg::mag_t'(det_s4_reg);
        for (int k = 0; k < NM; k++)
        begin
            nmag_s5_next[k] = num_s4_reg[k][sminv_pkg::CW-1]
                            ? sminv_pkg::mag_t'(-sminv_pkg::det_t'(num_s4_reg[k]))
                            : sminv_pkg::mag_t'(sminv_pkg::det_t'(num_s4_reg[k]));
            neg_s5_next[k]  = num_s4_reg[k][sminv_pkg::CW-1] ^ det_s4_reg[DTW-1];
            ovf_s5_next[k]  = (nmag_s5_next[k] >= dmag_s5_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            nmag_s5_reg <= nmag_s5_next;
            dmag_s5_reg <= dmag_s5_next;
            neg_s5_reg  <= neg_s5_next;
            ovf_s5_reg  <= ovf_s5_next;
            sing_s5_reg <= (det_s4_reg == '0);
        end
    end

    // divide stages: one quotient bit per stage
    always_comb
    begin
        for (int j = 0; j < QW; j++)
        begin
            for (int k = 0; k < NM; k++)
            begin
                logic [DTW:0]    t;
                sminv_pkg::mag_t rin;
                sminv_pkg::mag_t din;
                sminv_pkg::quo_t qin;
                rin = (j == 0) ? nmag_s5_reg[k] : rem_reg[(j == 0) ? 0 : j-1][k];
                din = (j == 0) ? dmag_s5_reg : dmag_reg[(j == 0) ? 0 : j-1];
                qin = (j == 0) ? '0 : q_reg[(j == 0) ? 0 : j-1][k];
                t   = {rin, 1'b0};
                if (t >= {1'b0, din})
                begin
                    rem_next[j][k] = sminv_pkg::mag_t'(t - {1'b0, din});
                    q_next[j][k]   = {qin[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[j][k] = t[DTW-1:0];
                    q_next[j][k]   = {qin[QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < QW; j++)
        begin
            if (en[SD+j])
            begin
                rem_reg[j] <= rem_next[j];
                q_reg[j]   <= q_next[j];
                if (j == 0)
                begin
                    dmag_reg[j] <= dmag_s5_reg;
                    neg_reg[j]  <= neg_s5_reg;
                    ovf_reg[j]  <= ovf_s5_reg;
                    sing_reg[j] <= sing_s5_reg;
                end
                else
                begin
                    dmag_reg[j] <= dmag_reg[(j == 0) ? 0 : j-1];
                    neg_reg[j]  <= neg_reg[(j == 0) ? 0 : j-1];
                    ovf_reg[j]  <= ovf_reg[(j == 0) ? 0 : j-1];
                    sing_reg[j] <= sing_reg[(j == 0) ? 0 : j-1];
                end
            end
        end
    end

    // output stage: saturation, sign and singular zeroing
    always_comb
    begin
        sat_next = 1'b0;
        for (int k = 0; k < NM; k++)
        begin
            logic [LW-1:0] lim;
            logic [LW-1:0] qx;
            logic [LW-1:0] val;
            logic          sat_k;
            lim   = neg_reg[QW-1][k] ? (LW'(1) << (DW - 1)) : ((LW'(1) << (DW - 1)) - LW'(1));
            qx    = LW'(q_reg[QW-1][k]);
            sat_k = ovf_reg[QW-1][k] || (qx > lim);
            val   = sat_k ? lim : qx;
            if (neg_reg[QW-1][k])
            begin
                val = -val;
            end
            res_next[k] = sing_reg[QW-1] ? '0 : val[DW-1:0];
            sat_next    = sat_next | (sat_k & !sing_reg[QW-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NSTG-1])
        begin
            res_reg      <= res_next;
            sat_reg      <= sat_next;
            sing_out_reg <= sing_reg[QW-1];
        end
    end

    assign i00       = res_reg[0];
    assign i01       = res_reg[1];
    assign i02       = res_reg[2];
    assign i10       = res_reg[3];
    assign i11       = res_reg[4];
    assign i12       = res_reg[5];
    assign i20       = res_reg[6];
    assign i21       = res_reg[7];
    assign i22       = res_reg[8];
    assign singular  = sing_out_reg;
    assign saturated = sat_reg;

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && singular) |-> (!saturated && i00 == 0 && i01 == 0 && i02 == 0
            && i10 == 0 && i11 == 0 && i12 == 0 && i20 == 0 && i21 == 0 && i22 == 0))
        else $error("singular result with nonzero entries");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[0] && !en[0]) |-> (out_valid && !out_ready))
        else $error("pipeline stalled without output backpressure");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_ready) |-> (vld_reg == '1))
        else $error("input blocked while a stage is empty");

endmodule
